FILE: rtl/lpct_pkg.sv
// Shared types and constants for the LRU page tag cache.
package lpct_pkg;

  localparam int PAGE_ID_W = 31;
  localparam int SLOT_W    = 4;
  localparam int CAP_W     = 5;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // Register index as decoded from the word address
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

  typedef struct packed {
    logic                 hit;
    logic [SLOT_W-1:0]    slot;
    logic                 filled;
    logic                 failed;
    logic                 evict_valid;
    logic [PAGE_ID_W-1:0] evict_page_id;
  } lpct_result_t;

endpackage

FILE: rtl/lpct_if.sv
// Handshake channels for page accesses and their results.
interface lpct_req_if;
  logic                          valid;
  logic                          ready;
  logic [lpct_pkg::PAGE_ID_W-1:0] page_id;
  logic                          load_ok;

  modport source (output valid, output page_id, output load_ok, input ready);
  modport sink (input valid, input page_id, input load_ok, output ready);
endinterface

interface lpct_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [lpct_pkg::SLOT_W-1:0]    slot;
  logic                           filled;
  logic                           failed;
  logic                           evict_valid;
  logic [lpct_pkg::PAGE_ID_W-1:0] evict_page_id;

  modport source (output valid, output hit, output slot, output filled, output failed,
                  output evict_valid, output evict_page_id, input ready);
  modport sink (input valid, input hit, input slot, input filled, input failed,
                input evict_valid, input evict_page_id, output ready);
endinterface

FILE: rtl/lpct_store.sv
// Tag store with parallel lookup, age-based LRU tracking and victim selection.
module lpct_store #(
  parameter int ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [lpct_pkg::CAP_W-1:0]     capacity,
  input  logic                           update,
  input  logic [lpct_pkg::PAGE_ID_W-1:0] page_id,
  input  logic                           load_ok,
  output lpct_pkg::lpct_result_t         result
);
  import lpct_pkg::*;

  localparam int IW   = $clog2(ENTRIES);
  localparam int AW   = $clog2(ENTRIES);
  localparam int OW   = $clog2(ENTRIES + 1);
  localparam int CMPW = ((OW > CAP_W) ? OW : CAP_W) + 1;
  localparam int SXW  = (IW > SLOT_W) ? IW : SLOT_W;

  logic [PAGE_ID_W-1:0] entry_tag   [ENTRIES];
  logic                 entry_valid [ENTRIES];
  logic [AW-1:0]        entry_age   [ENTRIES];
  logic [OW-1:0]        occupancy;

  logic [ENTRIES-1:0] match;
  logic               hit_any;
  logic [IW-1:0]      hit_idx;
  logic [IW-1:0]      free_idx;
  logic [IW-1:0]      victim_idx;
  logic [AW-1:0]      oldest_age;
  logic [CMPW-1:0]    cap_eff;
  logic [CMPW-1:0]    occ_plus;
  logic               do_evict;
  logic               do_fill;
  logic               do_touch;
  logic [IW-1:0]      sel_idx;
  logic [AW-1:0]      sel_age;
  logic [SXW-1:0]     slot_x;

  assign oldest_age = AW'(occupancy - OW'(1));

  // Lowest-index priority picks for hit, free slot and victim
  always_comb begin
    hit_idx    = '0;
    free_idx   = '0;
    victim_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = entry_valid[i] && (entry_tag[i] == page_id);
      if (match[i]) hit_idx = IW'(i);
      if (!entry_valid[i]) free_idx = IW'(i);
      if (entry_valid[i] && (entry_age[i] == oldest_age)) victim_idx = IW'(i);
    end
  end

  assign hit_any = |match;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CMPW'(1);
    end else if (CMPW'(capacity) > CMPW'(ENTRIES)) begin
      cap_eff = CMPW'(ENTRIES);
    end else begin
      cap_eff = CMPW'(capacity);
    end
  end

  assign occ_plus = CMPW'(occupancy) + CMPW'(1);
  assign do_evict = !hit_any && load_ok &&
                    ((occ_plus > cap_eff) || (occupancy == OW'(ENTRIES)));
  assign do_fill  = !hit_any && load_ok && !do_evict;
  assign do_touch = hit_any || do_evict;
  assign sel_idx  = hit_any ? hit_idx : victim_idx;
  assign sel_age  = hit_any ? entry_age[hit_idx] : oldest_age;

  always_comb begin
    if (hit_any) begin
      slot_x = SXW'(hit_idx);
    end else if (!load_ok) begin
      slot_x = '0;
    end else if (do_evict) begin
      slot_x = SXW'(victim_idx);
    end else begin
      slot_x = SXW'(free_idx);
    end
  end

  always_comb begin
    result.hit           = hit_any;
    result.slot          = slot_x[SLOT_W-1:0];
    result.filled        = !hit_any && load_ok;
    result.failed        = !hit_any && !load_ok;
    result.evict_valid   = do_evict;
    result.evict_page_id = do_evict ? entry_tag[victim_idx] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        entry_valid[i] <= 1'b0;
        entry_age[i]   <= '0;
      end
    end else if (update) begin
      if (do_fill) occupancy <= occupancy + OW'(1);
      for (int i = 0; i < ENTRIES; i++) begin
        if (do_touch) begin
          // promote the selected entry, age those that were younger
          if (IW'(i) == sel_idx) begin
            entry_age[i] <= '0;
          end else if (entry_valid[i] && (entry_age[i] < sel_age)) begin
            entry_age[i] <= entry_age[i] + AW'(1);
          end
        end else if (do_fill) begin
          if (IW'(i) == free_idx) begin
            entry_valid[i] <= 1'b1;
            entry_age[i]   <= '0;
          end else if (entry_valid[i]) begin
            entry_age[i] <= entry_age[i] + AW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      if (do_evict) begin
        entry_tag[victim_idx] <= page_id;
      end else if (do_fill) begin
        entry_tag[free_idx] <= page_id;
      end
    end
  end

endmodule

FILE: rtl/lru_page_cache_tags.sv
// Top level of the LRU page tag cache: channels, register port and stage control.
//
// Fully associative page tag cache with least-recently-used replacement. Each request beat
// is looked up against all entries in parallel from an input register; the state update and
// the result are written in the same cycle, so one access is taken every clock while the
// result side does not stall; each result is held in the output register. The output register
// lets a new request in while a result still waits; throughput drops only when the result
// side stalls. The single register, capacity (byte address 0), sets how many entries fill
// before the least recent one is evicted; 0 acts as 1 and values above ENTRIES act as
// ENTRIES. Write it only while the block is idle.
module lru_page_cache_tags #(
  parameter int ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  lpct_req_if.sink                     req,
  lpct_rsp_if.source                   rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lpct_pkg::PADDR_W-1:0] paddr,
  input  logic [lpct_pkg::PDATA_W-1:0] pwdata,
  output logic [lpct_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import lpct_pkg::*;

  logic [CAP_W-1:0]     capacity;
  logic                 stage_valid;
  logic [PAGE_ID_W-1:0] stage_page_id;
  logic                 stage_load_ok;
  logic                 out_valid;
  lpct_result_t         out_result;
  lpct_result_t         result;
  logic                 advance;
  logic                 cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign prdata    = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_write) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign advance   = stage_valid && (!out_valid || rsp.ready);
  assign req.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.ready) begin
      stage_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stage_page_id <= req.page_id;
      stage_load_ok <= req.load_ok;
    end
  end

  lpct_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .capacity (capacity),
    .update   (advance),
    .page_id  (stage_page_id),
    .load_ok  (stage_load_ok),
    .result   (result)
  );

  // hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_result <= result;
  end

  assign rsp.valid         = out_valid;
  assign rsp.hit           = out_result.hit;
  assign rsp.slot          = out_result.slot;
  assign rsp.filled        = out_result.filled;
  assign rsp.failed        = out_result.failed;
  assign rsp.evict_valid   = out_result.evict_valid;
  assign rsp.evict_page_id = out_result.evict_page_id;

endmodule

FILE: tb/tb_lru_page_cache_tags.sv
// Self-checking testbench for the LRU page tag cache: directed and random page accesses.
module tb_lru_page_cache_tags;
  import lpct_pkg::*;

  localparam int SLOTS      = 16;
  localparam int CAP_REG    = int'(REG_CAPACITY);
  localparam int SPARE_REG  = 1;
  localparam int IDLE_PCT   = 32;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  lpct_req_if req_ch();
  lpct_rsp_if rsp_ch();

  lru_page_cache_tags #(.ENTRIES(SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Shadow of the tag store
  logic [PAGE_ID_W-1:0] shadow_tag [SLOTS];
  bit                   shadow_valid [SLOTS];
  int                   shadow_age [SLOTS];
  int                   shadow_occ;
  logic [CAP_W-1:0]     cap_setting;

  lpct_result_t pending_results[$];
  int mismatch_count;
  int cycle_count;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[lru_page_cache_tags] ERROR");
      $finish;
    end
  end

  always @(posedge clk) rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

  // Make slot s the newest; valid entries younger than it age by one.
  function automatic void make_newest(int s);
    int a;
    a = shadow_age[s];
    for (int i = 0; i < SLOTS; i++)
      if (shadow_valid[i] && i != s && shadow_age[i] < a) shadow_age[i]++;
    shadow_age[s] = 0;
  endfunction

  function automatic lpct_result_t cache_access(logic [PAGE_ID_W-1:0] id, logic ok);
    lpct_result_t r;
    int s;
    int eff;
    int oldest;
    bit found;
    r = '0;
    s = 0;
    found = 1'b0;
    for (int i = 0; i < SLOTS; i++)
      if (!found && shadow_valid[i] && shadow_tag[i] == id) begin
        s = i;
        found = 1'b1;
      end
    if (found) begin
      make_newest(s);
      r.hit = 1'b1;
    end else if (!ok) begin
      r.failed = 1'b1;
      s = 0;
    end else begin
      eff = (cap_setting == 0) ? 1 : (int'(cap_setting) > SLOTS ? SLOTS : int'(cap_setting));
      if (shadow_occ + 1 > eff || shadow_occ >= SLOTS) begin
        // reuse the slot of the oldest entry; first one wins on a tie
        oldest = -1;
        for (int i = 0; i < SLOTS; i++)
          if (shadow_valid[i] && shadow_age[i] > oldest) begin
            oldest = shadow_age[i];
            s = i;
          end
        r.evict_valid = 1'b1;
        r.evict_page_id = shadow_tag[s];
        shadow_tag[s] = id;
        make_newest(s);
      end else begin
        s = SLOTS;
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!shadow_valid[i]) s = i;
        for (int i = 0; i < SLOTS; i++)
          if (shadow_valid[i]) shadow_age[i]++;
        shadow_valid[s] = 1'b1;
        shadow_tag[s] = id;
        shadow_age[s] = 0;
        shadow_occ++;
      end
      r.filled = 1'b1;
    end
    r.slot = s[SLOT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string field_name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field_name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin : result_check
    lpct_result_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result beat with nothing expected, actual slot %0h", $time, rsp_ch.slot);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("hit", 32'(exp_r.hit), 32'(rsp_ch.hit));
        check_field("slot", 32'(exp_r.slot), 32'(rsp_ch.slot));
        check_field("filled", 32'(exp_r.filled), 32'(rsp_ch.filled));
        check_field("failed", 32'(exp_r.failed), 32'(rsp_ch.failed));
        check_field("evict_valid", 32'(exp_r.evict_valid), 32'(rsp_ch.evict_valid));
        check_field("evict_page_id", 32'(exp_r.evict_page_id), 32'(rsp_ch.evict_page_id));
      end
    end
  end

  task automatic send_access(logic [PAGE_ID_W-1:0] id, logic ok);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    req_ch.valid   <= 1'b1;
    req_ch.page_id <= id;
    req_ch.load_ok <= ok;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(cache_access(id, ok));
  endtask

  // Hold off until every result is back, then let the pipe settle.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic reg_write(int idx, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == CAP_REG) cap_setting = value[CAP_W-1:0];
  endtask

  task automatic test_basic_access();
    send_access('0, 1'b1);
    send_access('1, 1'b1);
    send_access('0, 1'b0);                // hit ignores a failing load
    send_access(31'h2AAA_AAAA, 1'b0);     // miss with failed load
    send_access(31'h5555_5555, 1'b1);
    send_access('1, 1'b1);
  endtask

  task automatic test_capacity_extremes();
    drain();
    // capacity below occupancy: every fill evicts one entry
    reg_write(CAP_REG, 32'd1);
    send_access(31'h0000_1234, 1'b1);
    send_access(31'h0000_1234, 1'b1);
    drain();
    reg_write(CAP_REG, 32'd0);           // acts as one
    send_access(31'h0000_4321, 1'b1);
    drain();
  endtask

  task automatic test_full_store();
    reg_write(CAP_REG, 32'hFFFF_FFFF);   // masked to 31, acts as the full store
    @(posedge clk);
    reg_write(SPARE_REG, 32'd1);         // unknown register, ignored
    for (int i = 0; i < 13; i++) send_access(31'h4000_0000 | 31'(i), 1'b1);
    send_access(31'h7FFF_0001, 1'b1);
    send_access(31'h7FFF_0002, 1'b1);
  endtask

  task automatic random_phase(logic [PDATA_W-1:0] cap_word, int pool_size, bit quiet);
    logic [PAGE_ID_W-1:0] pool [32];
    logic [PAGE_ID_W-1:0] id;
    drain();
    reg_write(CAP_REG, cap_word);
    calm = quiet;
    for (int i = 0; i < 32; i++) pool[i] = PAGE_ID_W'($urandom);
    for (int n = 0; n < 225; n++) begin
      if ($urandom_range(0, 99) < 85) id = pool[$urandom_range(0, pool_size - 1)];
      else id = PAGE_ID_W'($urandom);
      // churn the working set so old pages age out
      if ($urandom_range(0, 99) < 8) pool[$urandom_range(0, pool_size - 1)] = PAGE_ID_W'($urandom);
      send_access(id, $urandom_range(0, 99) < 80);
    end
    calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    random_phase(32'd16, 24, 1'b0);
    random_phase(32'd1, 6, 1'b0);
    random_phase(32'd31, 20, 1'b1);
    random_phase(32'd0, 4, 1'b0);
    random_phase(32'($urandom_range(2, 15)), $urandom_range(2, 32), 1'b0);
    random_phase({$urandom} | 32'($urandom_range(0, 31)), $urandom_range(2, 32), 1'b0);
  endtask

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.page_id = '0;
    req_ch.load_ok = 1'b0;
    rsp_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatch_count = 0;
    cycle_count = 0;
    cap_setting = CAPACITY_RESET;
    shadow_occ = 0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_tag[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_age[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_access();
    test_capacity_extremes();
    test_full_store();
    test_random_traffic();

    drain();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[lru_page_cache_tags] OK");
    end else begin
      $display("[lru_page_cache_tags] ERROR");
    end
    $finish;
  end

endmodule
